FILE: rtl/tnst_pkg.sv
// tnst_pkg: shared constants, types and helpers for the top-n sorted tracker
// used by tnst_cell and top_n_sorted_tracker; depends on nothing
package tnst_pkg;

  localparam int CELLS = 16;
  localparam int CNT_W = $clog2(CELLS + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DUMP   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  // per-cell control, decoded in the top level from fill and kept counts
  typedef struct packed {
    logic ins;    // insert request this cycle
    logic rot;    // rotate chain toward cell 0 (dump step)
    logic occ;    // cell index below fill count
    logic cap;    // cell index below effective kept count
    logic at_n;   // cell index equals fill count
    logic first;  // head of chain
    logic tail;   // cell index equals fill count minus one
  } cell_ctrl_t;

  function automatic logic [CNT_W-1:0] eff_keep(logic [4:0] k);
    int v;
    v = int'(k);
    if (v < 1) v = 1;
    if (v > CELLS) v = CELLS;
    return CNT_W'(v);
  endfunction

endpackage

FILE: rtl/tnst_cell.sv
// tnst_cell: one compare-and-shift cell holding a score and an id
// depends on tnst_pkg
module tnst_cell
  import tnst_pkg::*;
(
  input  logic               clk_i,
  input  cell_ctrl_t         ctrl_i,
  input  logic signed [31:0] new_score_i,
  input  logic        [15:0] new_id_i,
  input  logic               hit_left_i,
  input  logic signed [31:0] left_score_i,
  input  logic        [15:0] left_id_i,
  input  logic signed [31:0] right_score_i,
  input  logic        [15:0] right_id_i,
  input  logic signed [31:0] head_score_i,
  input  logic        [15:0] head_id_i,
  output logic               hit_o,
  output logic signed [31:0] score_o,
  output logic        [15:0] id_o
);

  logic signed [31:0] score_q, score_d;
  logic        [15:0] id_q, id_d;
  logic               shift, take_new;

  assign hit_o   = ctrl_i.occ && (new_score_i <= score_q);
  assign score_o = score_q;
  assign id_o    = id_q;

  // left neighbor already claimed the new entry: take its old contents
  assign shift    = !ctrl_i.first && hit_left_i && (ctrl_i.occ || ctrl_i.at_n);
  assign take_new = !(!ctrl_i.first && hit_left_i) && (hit_o || ctrl_i.at_n);

  always_comb begin
    score_d = score_q;
    id_d    = id_q;
    if (ctrl_i.ins && ctrl_i.cap) begin
      if (shift) begin
        score_d = left_score_i;
        id_d    = left_id_i;
      end else if (take_new) begin
        score_d = new_score_i;
        id_d    = new_id_i;
      end
    end else if (ctrl_i.rot && ctrl_i.occ) begin
      if (ctrl_i.tail) begin
        score_d = head_score_i;
        id_d    = head_id_i;
      end else begin
        score_d = right_score_i;
        id_d    = right_id_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    score_q <= score_d;
    id_q    <= id_d;
  end

endmodule

FILE: rtl/top_n_sorted_tracker.sv
// top_n_sorted_tracker: keeps the best (lowest) scored results in rank order
// built from a chain of tnst_cell instances; depends on tnst_pkg
//
// usage:
//   s_axis: one request per item. tuser carries cmd (insert, dump, clear),
//   tdata carries new_score and new_id. insert and clear requests keep
//   s_axis_tready high, so such requests are accepted back to back.
//   a dump request walks the list out on m_axis, one entry per cycle at
//   best: the chain rotates toward cell 0 once per entry and cell 0 feeds
//   the output register. a dump of n entries holds s_axis_tready low
//   until its last entry is loaded; after n rotations the list is back in
//   its original order. the request sets ST_DUMP, which then loads the first result.
//   m_axis: tdata holds rank, out_score, out_id; tlast marks the final entry.
//   a stalled receiver holds the output register and freezes the dump walk.
//   cfg: write of keep_count, always ready; a lower value drops the worst
//   stored entries at once. write it only while the block is idle; the
//   block itself does not enforce this. reset: list empty, keep_count 16,
//   cells not cleared; only entries below the fill count are ever read.

module top_n_sorted_tracker
  import tnst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // new_score[31:0], new_id[47:32]
  input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // rank[3:0], out_score[35:4], out_id[51:36], zero pad
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i
);

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_e;

  state_e             state_q;
  logic [4:0]         keep_q;
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic [CNT_W-1:0]   cnt_q;
  logic [CNT_W-1:0]   keff, keff_new;

  logic               out_valid_q;
  logic [3:0]         out_rank_q;
  logic signed [31:0] out_score_q;
  logic [15:0]        out_id_q;
  logic               out_last_q;

  logic               in_acc, cfg_acc, ins, step, dump_last;
  logic signed [31:0] new_score;
  logic [15:0]        new_id;

  cell_ctrl_t         ctrl  [CELLS];
  logic               hit   [CELLS];
  logic signed [31:0] c_score [CELLS];
  logic [15:0]        c_id  [CELLS];

  assign new_score = s_axis_tdata[31:0];
  assign new_id    = s_axis_tdata[47:32];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign cfg_acc       = cfg_valid_i;

  assign keff     = eff_keep(keep_q);
  assign keff_new = eff_keep(cfg_data_i);

  assign ins = in_acc && (s_axis_tuser == CMD_INSERT);

  // dump step: move one entry into the output register when it is free
  assign step      = (state_q == ST_DUMP) && (!out_valid_q || m_axis_tready);
  assign dump_last = (CNT_W'(cnt_q + 1'b1) == fill_q);

  // per-cell control from its index against fill and kept counts
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    assign ctrl[i].ins   = ins;
    assign ctrl[i].rot   = step;
    assign ctrl[i].occ   = (CNT_W'(i) < fill_q);
    assign ctrl[i].cap   = (CNT_W'(i) < keff);
    assign ctrl[i].at_n  = (CNT_W'(i) == fill_q);
    assign ctrl[i].first = (i == 0);
    assign ctrl[i].tail  = (CNT_W'(i + 1) == fill_q);

    tnst_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl[i]),
      .new_score_i   (new_score),
      .new_id_i      (new_id),
      .hit_left_i    ((i == 0) ? 1'b0 : hit[(i == 0) ? 0 : i - 1]),
      .left_score_i  (c_score[(i == 0) ? 0 : i - 1]),
      .left_id_i     (c_id[(i == 0) ? 0 : i - 1]),
      .right_score_i (c_score[(i == CELLS - 1) ? i : i + 1]),
      .right_id_i    (c_id[(i == CELLS - 1) ? i : i + 1]),
      .head_score_i  (c_score[0]),
      .head_id_i     (c_id[0]),
      .hit_o         (hit[i]),
      .score_o       (c_score[i]),
      .id_o          (c_id[i])
    );
  end

  // fill count: insert grows until full, clear empties, config truncates
  always_comb begin
    fill_d = fill_q;
    if (cfg_acc) begin
      if (fill_q > keff_new) fill_d = keff_new;
    end else if (in_acc) begin
      case (s_axis_tuser)
        CMD_INSERT: if (fill_q < keff) fill_d = CNT_W'(fill_q + 1'b1);
        CMD_CLEAR:  fill_d = '0;
        default:    fill_d = fill_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      keep_q      <= 5'd16;
      fill_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (cfg_acc) keep_q <= cfg_data_i;
      // a new entry loads the output register, otherwise a taken one frees it
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc && (s_axis_tuser == CMD_DUMP) && (fill_q != '0)) begin
            state_q <= ST_DUMP;
            cnt_q   <= '0;
          end
        end
        ST_DUMP: begin
          if (step) begin
            cnt_q <= CNT_W'(cnt_q + 1'b1);
            if (dump_last) state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_rank_q  <= 4'(cnt_q);
      out_score_q <= c_score[0];
      out_id_q    <= c_id[0];
      out_last_q  <= dump_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {4'd0, out_id_q, out_score_q, out_rank_q};

  // list never holds more than the effective kept count
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= keff)
    else $error("fill count above kept count");

  // no new request taken while a dump walks the chain
  a_dump_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP) |-> !s_axis_tready)
    else $error("request accepted during dump");

  // insert into a list with room grows it by one
  a_ins_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ins && !cfg_acc && (fill_q < keff)) |=> (fill_q == CNT_W'($past(fill_q) + 1'b1)))
    else $error("insert did not grow list");

  // a dump step never overwrites an untaken result
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> ($stable(out_score_q) && $stable(out_rank_q)))
    else $error("pending result overwritten");

endmodule

FILE: bench/tb_top_n_sorted_tracker.sv
`timescale 1ns / 100ps
// tb_top_n_sorted_tracker: self-checking bench for the top-n sorted tracker, a
// directed table then random phases, results checked against a local ranking
// predictor; depends on tnst_pkg and top_n_sorted_tracker
module tb_top_n_sorted_tracker
  import tnst_pkg::*;
();

  // no request moved on any channel for this long means the block hung;
  // the longest legal quiet stretch is a config drain or a random idle gap
  localparam int IDLE_LIMIT   = 400;
  // cycles left for a dump walk to finish its last rotation
  localparam int DRAIN_GAP    = CELLS + 4;
  localparam int RANDOM_ITEMS = 120;
  localparam int REPORT_MAX   = 10;

  // command code the block must ignore
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum logic {ROW_REQ, ROW_KEEP} row_kind_e;
  // how a dump row is checked: by the predictor, or typed in by hand
  typedef enum logic [1:0] {BY_MODEL, SEE_EMPTY, SEE_ONE} check_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  cmd;
    logic [31:0] score;  // for a typed dump: the one score expected
    logic [15:0] id;     // for a typed dump: the one id expected
    logic [4:0]  keep;
    check_e      check;
  } row_t;

  typedef struct packed {
    logic [3:0]         rank;
    logic signed [31:0] score;
    logic [15:0]        id;
    logic               last;
  } entry_t;

  localparam int DIRECTED_ROWS = 27;
  localparam row_t PLAN [0:DIRECTED_ROWS-1] = '{
    // list is empty after reset
    '{ROW_REQ,  CMD_DUMP,   32'h0000_0000, 16'h0000, 5'd0,  SEE_EMPTY},
    // lowest score with all id bits set
    '{ROW_REQ,  CMD_INSERT, 32'h8000_0000, 16'hFFFF, 5'd0,  BY_MODEL},
    '{ROW_REQ,  CMD_DUMP,   32'h8000_0000, 16'hFFFF, 5'd0,  SEE_ONE},
    '{ROW_REQ,  CMD_CLEAR,  32'h0000_0000, 16'h0000, 5'd0,  BY_MODEL},
    // highest score with all id bits clear
    '{ROW_REQ,  CMD_INSERT, 32'h7FFF_FFFF, 16'h0000, 5'd0,  BY_MODEL},
    '{ROW_REQ,  CMD_DUMP,   32'h7FFF_FFFF, 16'h0000, 5'd0,  SEE_ONE},
    // tie on zero: the newer id must rank first
    '{ROW_REQ,  CMD_INSERT, 32'h0000_0000, 16'h0001, 5'd0,  BY_MODEL},
    '{ROW_REQ,  CMD_INSERT, 32'h0000_0000, 16'h0002, 5'd0,  BY_MODEL},
    '{ROW_REQ,  CMD_INSERT, 32'hFFFF_FFFF, 16'h0003, 5'd0,  BY_MODEL},
    '{ROW_REQ,  CMD_INSERT, 32'h0001_0000, 16'h0004, 5'd0,  BY_MODEL},
    // unused command leaves the list alone
    '{ROW_REQ,  CMD_UNUSED, 32'hAAAA_5555, 16'h5A5A, 5'd0,  BY_MODEL},
    '{ROW_REQ,  CMD_DUMP,   32'h0000_0000, 16'h0000, 5'd0,  BY_MODEL},
    // lowering the kept count drops the worst entries
    '{ROW_KEEP, CMD_INSERT, 32'h0000_0000, 16'h0000, 5'd2,  BY_MODEL},
    '{ROW_REQ,  CMD_DUMP,   32'h0000_0000, 16'h0000, 5'd0,  BY_MODEL},
    // full list: worse than all is dropped, better pushes the worst out
    '{ROW_REQ,  CMD_INSERT, 32'h7FFF_FFFF, 16'h0005, 5'd0,  BY_MODEL},
    '{ROW_REQ,  CMD_INSERT, 32'h8000_0000, 16'h0006, 5'd0,  BY_MODEL},
    '{ROW_REQ,  CMD_DUMP,   32'h0000_0000, 16'h0000, 5'd0,  BY_MODEL},
    // kept count zero behaves as one
    '{ROW_KEEP, CMD_INSERT, 32'h0000_0000, 16'h0000, 5'd0,  BY_MODEL},
    '{ROW_REQ,  CMD_INSERT, 32'h1234_5678, 16'h0007, 5'd0,  BY_MODEL},
    '{ROW_REQ,  CMD_DUMP,   32'h8000_0000, 16'h0006, 5'd0,  SEE_ONE},
    // kept counts above the cell count behave as the cell count
    '{ROW_KEEP, CMD_INSERT, 32'h0000_0000, 16'h0000, 5'd31, BY_MODEL},
    '{ROW_REQ,  CMD_CLEAR,  32'h0000_0000, 16'h0000, 5'd0,  BY_MODEL},
    '{ROW_REQ,  CMD_DUMP,   32'h0000_0000, 16'h0000, 5'd0,  SEE_EMPTY},
    '{ROW_KEEP, CMD_INSERT, 32'h0000_0000, 16'h0000, 5'd17, BY_MODEL},
    '{ROW_REQ,  CMD_INSERT, 32'h5555_AAAA, 16'h8001, 5'd0,  BY_MODEL},
    '{ROW_REQ,  CMD_DUMP,   32'h0000_0000, 16'h0000, 5'd0,  BY_MODEL},
    '{ROW_KEEP, CMD_INSERT, 32'h0000_0000, 16'h0000, 5'd16, BY_MODEL}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // new_score[31:0], new_id[47:32]
  logic [1:0]  s_axis_tuser = '0;   // cmd[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;        // rank[3:0], out_score[35:4], out_id[51:36], zero pad
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i = '0;

  // predictor state: the ranked list as the block should hold it
  logic signed [31:0] ranked_score [CELLS];
  logic [15:0]        ranked_id [CELLS];
  int unsigned        held_count = 0;
  logic [4:0]         keep_setting = 5'd16;

  // dump entries still owed by the block, oldest first
  entry_t pending_entries [$];

  int  fail_count = 0;
  int  quiet_cycles = 0;
  bit  calm_phase = 1'b0;   // no idling on either side while set
  wire moved = (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
               (cfg_valid_i && cfg_ready_o);

  top_n_sorted_tracker DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // kept count after clamping to 1..CELLS
  function automatic int unsigned kept_limit();
    int unsigned k;
    k = keep_setting;
    if (k < 1) k = 1;
    if (k > CELLS) k = CELLS;
    return k;
  endfunction

  function automatic int draw_gap();
    if (calm_phase) return 0;
    return $urandom_range(0, 19);
  endfunction

  // many small scores so ties are common, plus the extremes and full range
  function automatic logic signed [31:0] rand_score();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 32'sh8000_0000;
    if (sel == 1) return 32'sh7FFF_FFFF;
    if (sel < 6) return int'($urandom_range(0, 8)) - 4;
    return $urandom();
  endfunction

  function automatic void log_fault(input string what);
    fail_count++;
    if (fail_count <= REPORT_MAX) $display("%t mismatch: %s", $realtime, what);
  endfunction

  // update the ranked list for one accepted request, queue any dump entries
  function automatic void apply_request(input logic [1:0] cmd,
                                        input logic signed [31:0] score,
                                        input logic [15:0] id, input check_e check);
    int unsigned lim, n, pos, top;
    int i;
    logic found;
    entry_t e;
    lim = kept_limit();
    n = (held_count > lim) ? lim : held_count;
    case (cmd)
      CMD_INSERT: begin
        pos = n;
        found = 1'b0;
        for (i = 0; i < int'(n); i++) begin
          // goes ahead of the first entry that is equal or worse
          if (!found && score <= ranked_score[i]) begin
            pos = i;
            found = 1'b1;
          end
        end
        if (pos < n) begin
          top = (n < lim) ? n : lim - 1;
          for (i = int'(top); i > int'(pos); i--) begin
            ranked_score[i] = ranked_score[i-1];
            ranked_id[i] = ranked_id[i-1];
          end
          ranked_score[pos] = score;
          ranked_id[pos] = id;
          if (n < lim) n++;
        end else if (n < lim) begin
          ranked_score[n] = score;
          ranked_id[n] = id;
          n++;
        end
        held_count = n;
      end
      CMD_DUMP: begin
        if (check == SEE_ONE) begin
          e = '{4'd0, score, id, 1'b1};
          pending_entries = {pending_entries, e};
        end else if (check == BY_MODEL) begin
          for (i = 0; i < int'(n); i++) begin
            e = '{4'(i), ranked_score[i], ranked_id[i], (i == int'(n) - 1)};
            pending_entries = {pending_entries, e};
          end
        end
        held_count = n;
      end
      CMD_CLEAR: held_count = 0;
      default: ;
    endcase
  endfunction

  // one request on s_axis, held until accepted, then fed to the predictor
  task automatic issue_request(input logic [1:0] cmd, input logic signed [31:0] score,
                               input logic [15:0] id, input check_e check);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {id, score};
    s_axis_tuser <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    apply_request(cmd, score, id, check);
  endtask

  // kept count write, only once the block has gone quiet
  task automatic write_keep(input logic [4:0] value);
    int unsigned lim;
    s_axis_tvalid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    keep_setting = value;
    lim = kept_limit();
    if (held_count > lim) held_count = lim;
  endtask

  // sink: random stalls, every accepted entry checked against the oldest owed
  initial begin : sink
    int gap;
    entry_t got, want;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = draw_gap();
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got = '{m_axis_tdata[3:0], m_axis_tdata[35:4], m_axis_tdata[51:36], m_axis_tlast};
      if (pending_entries.size() == 0) begin
        log_fault($sformatf("unexpected entry rank %0d score %h id %h last %b",
                            got.rank, got.score, got.id, got.last));
      end else begin
        want = pending_entries.pop_front();
        if (got.rank !== want.rank || got.score !== want.score ||
            got.id !== want.id || got.last !== want.last)
          log_fault($sformatf("rank/score/id/last expected %0d %h %h %b got %0d %h %h %b",
                              want.rank, want.score, want.id, want.last,
                              got.rank, got.score, got.id, got.last));
      end
    end
  end

  // hang detector, counts only after reset is released
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (moved) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%t timeout: no request moved for %0d cycles", $realtime, quiet_cycles);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : source
    int r, i, burst, roll, random_items;
    logic [1:0] cmd;
    logic [4:0] k;
    random_items = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (r = 0; r < DIRECTED_ROWS; r++) begin
      if (PLAN[r].kind == ROW_KEEP) write_keep(PLAN[r].keep);
      else issue_request(PLAN[r].cmd, PLAN[r].score, PLAN[r].id, PLAN[r].check);
    end

    // random phases: optional kept count change and clear, a burst of
    // inserts with the odd dump or ignored command, then a closing dump
    while (random_items < RANDOM_ITEMS) begin
      calm_phase = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 7))
          0:       k = 5'd1;
          1:       k = 5'd16;
          2:       k = 5'd0;
          3:       k = 5'd31;
          default: k = 5'($urandom_range(0, 31));
        endcase
        write_keep(k);
      end
      if ($urandom_range(0, 2) == 0) begin
        issue_request(CMD_CLEAR, rand_score(), 16'($urandom_range(0, 65535)), BY_MODEL);
        random_items++;
      end
      burst = $urandom_range(0, 20);
      for (i = 0; i < burst; i++) begin
        roll = $urandom_range(0, 15);
        if (roll == 0) begin
          issue_request(CMD_UNUSED, rand_score(), 16'($urandom_range(0, 65535)), BY_MODEL);
        end else begin
          cmd = (roll == 1) ? CMD_DUMP : CMD_INSERT;
          issue_request(cmd, rand_score(), 16'($urandom_range(0, 65535)), BY_MODEL);
          random_items++;
        end
      end
      issue_request(CMD_DUMP, rand_score(), 16'($urandom_range(0, 65535)), BY_MODEL);
      random_items++;
    end

    s_axis_tvalid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/tnst_pkg.sv
rtl/tnst_cell.sv
rtl/top_n_sorted_tracker.sv
bench/tb_top_n_sorted_tracker.sv
